// ----- rtl/bde_pkg.sv -----
package bde_pkg;

    localparam int BYTE_W      = 8;
    localparam int KEY_COUNT   = 256;
    localparam int DEF_MAX_LEN = 64;

    localparam logic [BYTE_W-1:0] VERSION_RESET = 8'd1;

    typedef struct packed {
        logic clear_dict;
        logic define_key;
        logic store_char;
        logic load_pass;
        logic load_error;
        logic start_expand;
        logic emit_step;
    } bde_cmd_t;

    typedef struct packed {
        logic byte_zero;
        logic version_match;
        logic entry_hit;
        logic fill_full;
        logic emit_empty;
        logic emit_last;
        logic out_free;
    } bde_stat_t;

endpackage

// ----- rtl/byte_dictionary_expander.sv -----
// Byte dictionary expander: decodes a compressed file arriving one byte per request.
// Input channel in_valid/in_ready carries data_byte and file_start; file_start marks
// the version byte of a new file and clears the dictionary. Output channel
// out_valid/out_ready carries out_byte, run_last (last byte caused by one input
// request) and status (1 = bad version byte, out_byte 0). cfg_wr_en/cfg_wr_data
// write format_version; write it only while the block is idle.
// Latency: a pass-through or error result is valid the cycle after the input
// request is accepted. A dictionary hit reads the entry length and first string
// byte in the accepting cycle; its first byte then moves from the string read
// register into the output register, then one byte per cycle while out_ready is high.
// Throughput: one request per cycle for header, dictionary and pass-through bytes
// while the output is not stalled; a hit keeps in_ready low until its last byte
// is loaded or, for an empty entry, until the busy state ends.
// Reset: format_version returns to 1, the dictionary is empty and the next byte
// is taken as a version byte; no memory clearing pass is needed.
// Stall: while out_ready is low the output register holds its result and in_ready
// drops, so expansion pauses without losing bytes.
module byte_dictionary_expander
    import bde_pkg::*;
#(
    parameter int MAX_LEN = DEF_MAX_LEN
)
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              cfg_wr_en,
    input  logic [BYTE_W-1:0] cfg_wr_data,
    input  logic              in_valid,
    output logic              in_ready,
    input  logic [BYTE_W-1:0] data_byte,
    input  logic              file_start,
    output logic              out_valid,
    input  logic              out_ready,
    output logic [BYTE_W-1:0] out_byte,
    output logic              run_last,
    output logic              status
);

    bde_cmd_t  cmd;
    bde_stat_t stat;

    bde_ctrl u_ctrl (
        .clk        (clk),
        .rst_n      (rst_n),
        .in_valid   (in_valid),
        .file_start (file_start),
        .in_ready   (in_ready),
        .stat       (stat),
        .cmd        (cmd)
    );

    bde_datapath #(
        .MAX_LEN (MAX_LEN)
    ) u_datapath (
        .clk         (clk),
        .rst_n       (rst_n),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_wr_data (cfg_wr_data),
        .data_byte   (data_byte),
        .cmd         (cmd),
        .stat        (stat),
        .out_valid   (out_valid),
        .out_ready   (out_ready),
        .out_byte    (out_byte),
        .run_last    (run_last),
        .status      (status)
    );

endmodule

// ----- rtl/bde_ctrl.sv -----
module bde_ctrl
    import bde_pkg::*;
(
    input  logic      clk,
    input  logic      rst_n,
    input  logic      in_valid,
    input  logic      file_start,
    output logic      in_ready,
    input  bde_stat_t stat,
    output bde_cmd_t  cmd
);

    localparam logic [2:0] PH_VERSION = 3'd0;
    localparam logic [2:0] PH_MAPFLAG = 3'd1;
    localparam logic [2:0] PH_KEY     = 3'd2;
    localparam logic [2:0] PH_STRING  = 3'd3;
    localparam logic [2:0] PH_DATA    = 3'd4;
    localparam logic [2:0] PH_IGNORE  = 3'd5;

    logic [2:0] phase_reg;
    logic [2:0] phase_next;
    logic       busy_reg;
    logic       busy_next;
    logic [2:0] phase_eff;
    logic       accept;

    assign in_ready = !busy_reg && stat.out_free;
    assign accept   = in_valid && in_ready;

    always_comb
    begin
        phase_next = phase_reg;
        busy_next  = busy_reg;
        cmd        = '0;
        phase_eff  = file_start ? PH_VERSION : phase_reg;

        if (busy_reg)
        begin
            if (stat.emit_empty)
            begin
                busy_next = 1'b0;
            end
            else if (stat.out_free)
            begin
                cmd.emit_step = 1'b1;
                if (stat.emit_last)
                begin
                    busy_next = 1'b0;
                end
            end
        end
        else if (accept)
        begin
            cmd.clear_dict = file_start;
            case (phase_eff)
                PH_VERSION:
                begin
                    if (stat.version_match)
                    begin
                        phase_next = PH_MAPFLAG;
                    end
                    else
                    begin
                        phase_next     = PH_IGNORE;
                        cmd.load_error = 1'b1;
                    end
                end
                PH_MAPFLAG, PH_DATA:
                begin
                    if (phase_eff == PH_MAPFLAG && stat.byte_zero)
                    begin
                        phase_next = PH_KEY;
                    end
                    else
                    begin
                        phase_next = PH_DATA;
                        if (stat.entry_hit)
                        begin
                            cmd.start_expand = 1'b1;
                            busy_next        = 1'b1;
                        end
                        else
                        begin
                            cmd.load_pass = 1'b1;
                        end
                    end
                end
                PH_KEY:
                begin
                    if (stat.byte_zero)
                    begin
                        phase_next = PH_DATA;
                    end
                    else
                    begin
                        phase_next     = PH_STRING;
                        cmd.define_key = 1'b1;
                    end
                end
                PH_STRING:
                begin
                    if (stat.byte_zero)
                    begin
                        phase_next = PH_KEY;
                    end
                    else
                    begin
                        cmd.store_char = !stat.fill_full;
                    end
                end
                default:
                begin
                    phase_next = PH_IGNORE;
                end
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg <= PH_VERSION;
            busy_reg  <= 1'b0;
        end
        else
        begin
            phase_reg <= phase_next;
            busy_reg  <= busy_next;
        end
    end

`ifndef ASSERT_OFF
    a_emit_only_busy: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.emit_step |-> busy_reg)
        else $error("emit step outside expansion");

    a_expand_enters_busy: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.start_expand |=> busy_reg && phase_reg == PH_DATA)
        else $error("expansion did not start");

    a_one_load: assert property (@(posedge clk) disable iff (!rst_n)
        $onehot0({cmd.load_pass, cmd.load_error, cmd.emit_step, cmd.start_expand}))
        else $error("conflicting result loads");
`endif

endmodule

// ----- rtl/bde_datapath.sv -----
module bde_datapath
    import bde_pkg::*;
#(
    parameter int MAX_LEN = DEF_MAX_LEN
)
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              cfg_wr_en,
    input  logic [BYTE_W-1:0] cfg_wr_data,
    input  logic [BYTE_W-1:0] data_byte,
    input  bde_cmd_t          cmd,
    output bde_stat_t         stat,
    output logic              out_valid,
    input  logic              out_ready,
    output logic [BYTE_W-1:0] out_byte,
    output logic              run_last,
    output logic              status
);

    localparam int LW    = $clog2(MAX_LEN + 1);
    localparam int DEPTH = KEY_COUNT * MAX_LEN;
    localparam int AW    = $clog2(DEPTH);

    logic [BYTE_W-1:0]    version_reg;
    logic [KEY_COUNT-1:0] defined_reg;
    logic [LW-1:0]        len_mem [KEY_COUNT];
    logic [BYTE_W-1:0]    str_mem [DEPTH];

    logic [BYTE_W-1:0] cur_key_reg;
    logic [LW-1:0]     fill_reg;
    logic [BYTE_W-1:0] exp_key_reg;
    logic [LW-1:0]     idx_reg;
    logic [LW-1:0]     len_q_reg;
    logic [BYTE_W-1:0] str_q_reg;

    logic              out_valid_reg;
    logic              out_valid_next;
    logic [BYTE_W-1:0] out_byte_reg;
    logic              run_last_reg;
    logic              status_reg;

    logic [LW-1:0]     fill_plus1;
    logic [LW-1:0]     idx_plus1;
    logic [AW-1:0]     wr_addr;
    logic [AW-1:0]     rd_addr;
    logic              rd_en;
    logic              emit_last;

    assign fill_plus1 = LW'(fill_reg + 1'b1);
    assign idx_plus1  = LW'(idx_reg + 1'b1);
    assign emit_last  = idx_plus1 == len_q_reg;
    assign wr_addr    = AW'(AW'(cur_key_reg) * AW'(MAX_LEN) + AW'(fill_reg));
    assign rd_addr    = cmd.start_expand ? AW'(AW'(data_byte) * AW'(MAX_LEN))
                      : AW'(AW'(exp_key_reg) * AW'(MAX_LEN) + AW'(idx_plus1));
    assign rd_en      = cmd.start_expand || (cmd.emit_step && !emit_last);

    always_comb
    begin
        stat.byte_zero     = data_byte == '0;
        stat.version_match = data_byte == version_reg;
        stat.entry_hit     = defined_reg[data_byte];
        stat.fill_full     = fill_reg == LW'(MAX_LEN);
        stat.emit_empty    = len_q_reg == '0;
        stat.emit_last     = emit_last;
        stat.out_free      = !out_valid_reg || out_ready;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            version_reg <= VERSION_RESET;
        end
        else if (cfg_wr_en)
        begin
            version_reg <= cfg_wr_data;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            defined_reg <= '0;
            cur_key_reg <= '0;
            fill_reg    <= '0;
        end
        else if (cmd.clear_dict)
        begin
            defined_reg <= '0;
        end
        else if (cmd.define_key)
        begin
            defined_reg[data_byte] <= 1'b1;
            cur_key_reg            <= data_byte;
            fill_reg               <= '0;
        end
        else if (cmd.store_char)
        begin
            fill_reg <= fill_plus1;
        end
    end

    // entry length table: one write port, one registered read port
    always_ff @(posedge clk)
    begin
        if (cmd.define_key)
        begin
            len_mem[data_byte] <= '0;
        end
        else if (cmd.store_char)
        begin
            len_mem[cur_key_reg] <= fill_plus1;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.start_expand)
        begin
            len_q_reg <= len_mem[data_byte];
        end
    end

    // string store
    always_ff @(posedge clk)
    begin
        if (cmd.store_char)
        begin
            str_mem[wr_addr] <= data_byte;
        end
    end

    always_ff @(posedge clk)
    begin
        if (rd_en)
        begin
            str_q_reg <= str_mem[rd_addr];
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.start_expand)
        begin
            exp_key_reg <= data_byte;
            idx_reg     <= '0;
        end
        else if (cmd.emit_step)
        begin
            idx_reg <= idx_plus1;
        end
    end

    always_comb
    begin
        out_valid_next = out_valid_reg;
        if (cmd.load_pass || cmd.load_error || cmd.emit_step)
        begin
            out_valid_next = 1'b1;
        end
        else if (out_ready)
        begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else
        begin
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.load_pass)
        begin
            out_byte_reg <= data_byte;
            run_last_reg <= 1'b1;
            status_reg   <= 1'b0;
        end
        else if (cmd.load_error)
        begin
            out_byte_reg <= '0;
            run_last_reg <= 1'b1;
            status_reg   <= 1'b1;
        end
        else if (cmd.emit_step)
        begin
            out_byte_reg <= str_q_reg;
            run_last_reg <= emit_last;
            status_reg   <= 1'b0;
        end
    end

    assign out_valid = out_valid_reg;
    assign out_byte  = out_byte_reg;
    assign run_last  = run_last_reg;
    assign status    = status_reg;

`ifndef ASSERT_OFF
    a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
        (cmd.load_pass || cmd.load_error || cmd.emit_step) |-> (!out_valid_reg || out_ready))
        else $error("pending result overwritten");

    a_emit_in_range: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.emit_step |-> idx_reg < len_q_reg)
        else $error("expansion index past entry length");

    a_fill_bound: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.store_char |-> fill_reg < LW'(MAX_LEN))
        else $error("string fill past limit");
`endif

endmodule
